// ===== rtl/core/rcvc_pkg.sv =====
// shared types, character codes and reset values for the vehicle command controller
package rcvc_pkg;

    // item kinds carried in the opcode field
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_FAST  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_BLINK_HALF = 3'd0;
    localparam logic [2:0] REG_TURRET_MIN = 3'd1;
    localparam logic [2:0] REG_TURRET_MAX = 3'd2;
    localparam logic [2:0] REG_TURRET_STEP = 3'd3;
    localparam logic [2:0] REG_TURRET_GAP = 3'd4;
    localparam logic [2:0] REG_FIRE_HOLD  = 3'd5;
    localparam logic [2:0] REG_SPEED_BASE = 3'd6;
    localparam logic [2:0] REG_SPEED_SLOPE = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // received characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_FIVE = 8'h35;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;

    // h-bridge patterns, M1a M1b M2a M2b
    localparam logic [3:0] BRIDGE_STOP  = 4'h0;
    localparam logic [3:0] BRIDGE_FWD   = 4'hA;
    localparam logic [3:0] BRIDGE_BACK  = 4'h5;
    localparam logic [3:0] BRIDGE_LEFT  = 4'h9;
    localparam logic [3:0] BRIDGE_RIGHT = 4'h6;

    // register reset values
    localparam logic [15:0] RST_BLINK_HALF  = 16'd500;
    localparam logic [9:0]  RST_TURRET_MIN  = 10'd30;
    localparam logic [9:0]  RST_TURRET_MAX  = 10'd60;
    localparam logic [3:0]  RST_TURRET_STEP = 4'd2;
    localparam logic [7:0]  RST_TURRET_GAP  = 8'd25;
    localparam logic [7:0]  RST_FIRE_HOLD   = 8'd50;
    localparam logic [9:0]  RST_SPEED_BASE  = 10'd226;
    localparam logic [9:0]  RST_SPEED_SLOPE = 10'd109;

    // state reset values
    localparam logic [2:0] RST_SPEED      = 3'd1;
    localparam logic [9:0] RST_TURRET_POS = 10'd42;
    localparam logic [9:0] TURRET_PARK    = 10'd43;
    localparam logic [9:0] RST_FIRE_DRIVE = 10'd60;
    localparam logic [7:0] RST_FIRE_COUNT = 8'd20;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  bridge_pattern;
        logic        lamp_left;
        logic        lamp_right;
        logic        lights;
        logic        aim_light;
        logic        horn;
        logic [12:0] motor_compare;
        logic [9:0]  turret_compare;
        logic [9:0]  fire_compare;
        logic        command_done;
    } out_item_t;

    typedef struct packed {
        logic [15:0] blink_half_period;
        logic [9:0]  turret_min;
        logic [9:0]  turret_max;
        logic [3:0]  turret_step;
        logic [7:0]  turret_gap_ticks;
        logic [7:0]  fire_hold_ticks;
        logic [9:0]  speed_base;
        logic [9:0]  speed_slope;
    } cfg_t;

endpackage

// ===== rtl/core/rcvc_cfg.sv =====
// configuration register bank
module rcvc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcvc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rcvc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rcvc_pkg::cfg_t                     cfg_o
);
    import rcvc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_half_period <= RST_BLINK_HALF;
            cfg_reg.turret_min        <= RST_TURRET_MIN;
            cfg_reg.turret_max        <= RST_TURRET_MAX;
            cfg_reg.turret_step       <= RST_TURRET_STEP;
            cfg_reg.turret_gap_ticks  <= RST_TURRET_GAP;
            cfg_reg.fire_hold_ticks   <= RST_FIRE_HOLD;
            cfg_reg.speed_base        <= RST_SPEED_BASE;
            cfg_reg.speed_slope       <= RST_SPEED_SLOPE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLINK_HALF:  cfg_reg.blink_half_period <= cfg_data;
                REG_TURRET_MIN:  cfg_reg.turret_min        <= cfg_data[9:0];
                REG_TURRET_MAX:  cfg_reg.turret_max        <= cfg_data[9:0];
                REG_TURRET_STEP: cfg_reg.turret_step       <= cfg_data[3:0];
                REG_TURRET_GAP:  cfg_reg.turret_gap_ticks  <= cfg_data[7:0];
                REG_FIRE_HOLD:   cfg_reg.fire_hold_ticks   <= cfg_data[7:0];
                REG_SPEED_BASE:  cfg_reg.speed_base        <= cfg_data[9:0];
                REG_SPEED_SLOPE: cfg_reg.speed_slope       <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/rcvc_in_reg.sv =====
// input register stage
module rcvc_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rcvc_pkg::in_item_t s_data,
    input  logic               take_i,
    output logic               valid_o,
    output rcvc_pkg::in_item_t item_o
);
    import rcvc_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // room when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || take_i;
    assign valid_o = valid_reg;
    assign item_o  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_data;
        end
    end

endmodule

// ===== rtl/core/rcvc_core.sv =====
// command state, tick timers and result register
module rcvc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  rcvc_pkg::cfg_t      cfg_i,
    input  logic                in_valid_i,
    input  rcvc_pkg::in_item_t  item_i,
    output logic                take_o,
    output logic                m_valid,
    input  logic                m_ready,
    output rcvc_pkg::out_item_t m_data
);
    import rcvc_pkg::*;

    typedef enum logic [1:0] {
        BLINK_IDLE  = 2'd0,
        BLINK_START = 2'd1,
        BLINK_TURN  = 2'd2
    } blink_mode_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c == CH_F || c == CH_B || c == CH_L || c == CH_R || c == CH_S ||
               c == CH_A || c == CH_T || c == CH_D || c == CH_N;
    endfunction

    // one clamped turret step
    function automatic logic [9:0] turret_step_pos(input logic [9:0] pos,
                                                   input logic [9:0] lo,
                                                   input logic [9:0] hi,
                                                   input logic [3:0] st,
                                                   input logic       right);
        logic [10:0] up;
        logic [10:0] lo_lim;
        logic [9:0]  res;
        up     = {1'b0, pos} + {7'b0, st};
        lo_lim = {1'b0, lo} + {7'b0, st};
        if (right) begin
            res = (up < {1'b0, hi}) ? up[9:0] : hi;
        end else begin
            res = ({1'b0, pos} > lo_lim) ? (pos - {6'b0, st}) : lo;
        end
        return res;
    endfunction

    logic [7:0]  prev_reg,        prev_next;
    logic        armed_reg,       armed_next;
    logic [3:0]  drive_reg,       drive_next;
    logic [3:0]  bridge_reg,      bridge_next;
    logic [2:0]  speed_reg,       speed_next;
    logic [9:0]  tur_pos_reg,     tur_pos_next;
    logic [9:0]  tur_drive_reg,   tur_drive_next;
    logic        tur_ready_reg,   tur_ready_next;
    logic [7:0]  gap_cnt_reg,     gap_cnt_next;
    logic [9:0]  fire_drive_reg,  fire_drive_next;
    logic [7:0]  fire_cnt_reg,    fire_cnt_next;
    logic        siren_reg,       siren_next;
    logic        horn_reg,        horn_next;
    logic [1:0]  blink_req_reg,   blink_req_next;
    blink_mode_t blink_mode_reg,  blink_mode_next;
    logic [15:0] blink_cnt_reg,   blink_cnt_next;
    logic [1:0]  lamp_reg,        lamp_next;
    logic        lights_reg,      lights_next;
    logic        aim_reg,         aim_next;
    logic        m_valid_reg;
    out_item_t   m_data_reg,      m_data_next;

    logic        done;
    logic [7:0]  rx;
    logic [12:0] motor;

    assign take_o  = in_valid_i && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rx      = item_i.rx_byte;

    always_comb begin
        prev_next       = prev_reg;
        armed_next      = armed_reg;
        drive_next      = drive_reg;
        bridge_next     = bridge_reg;
        speed_next      = speed_reg;
        tur_pos_next    = tur_pos_reg;
        tur_drive_next  = tur_drive_reg;
        tur_ready_next  = tur_ready_reg;
        gap_cnt_next    = gap_cnt_reg;
        fire_drive_next = fire_drive_reg;
        fire_cnt_next   = fire_cnt_reg;
        siren_next      = siren_reg;
        horn_next       = horn_reg;
        blink_req_next  = blink_req_reg;
        blink_mode_next = blink_mode_reg;
        blink_cnt_next  = blink_cnt_reg;
        lamp_next       = lamp_reg;
        lights_next     = lights_reg;
        aim_next        = aim_reg;
        done            = 1'b0;

        unique case (item_i.opcode)
            OP_BYTE: begin
                if (prev_reg == CH_HASH && rx != CH_HASH) begin
                    armed_next = 1'b1;
                end else if (is_letter(prev_reg) && armed_reg) begin
                    armed_next = 1'b0;
                    done       = 1'b1;
                    unique case (prev_reg)
                        CH_F: begin
                            if (rx == CH_ONE) begin
                                drive_next     = 4'b1000;
                                tur_ready_next = 1'b1;
                            end else if (rx == CH_ZERO) begin
                                drive_next     = 4'b0000;
                                tur_ready_next = 1'b1;
                            end else if (rx == CH_I) begin
                                fire_drive_next = cfg_i.turret_min;
                                fire_cnt_next   = 8'd0;
                            end
                        end
                        CH_B: begin
                            if (rx == CH_ONE) begin
                                drive_next     = 4'b0100;
                                tur_ready_next = 1'b1;
                            end else if (rx == CH_ZERO) begin
                                drive_next     = 4'b0000;
                                tur_ready_next = 1'b1;
                            end else if (rx == CH_L || rx == CH_R) begin
                                blink_req_next = blink_req_reg |
                                                 ((rx == CH_L) ? 2'b10 : 2'b01);
                                if (blink_mode_reg == BLINK_IDLE) begin
                                    blink_mode_next = BLINK_START;
                                end
                            end
                        end
                        CH_L: begin
                            if (rx == CH_ONE || rx == CH_ZERO) begin
                                drive_next     = {2'b00, rx == CH_ONE, 1'b0};
                                tur_ready_next = 1'b1;
                            end
                        end
                        CH_R: begin
                            if (rx == CH_ONE || rx == CH_ZERO) begin
                                drive_next     = {3'b000, rx == CH_ONE};
                                tur_ready_next = 1'b1;
                            end
                        end
                        CH_S: begin
                            if (rx == CH_ONE) begin
                                siren_next     = 1'b1;
                                drive_next     = 4'b0000;
                                tur_ready_next = 1'b1;
                            end else if (rx == CH_ZERO) begin
                                siren_next = 1'b0;
                            end
                        end
                        CH_N: begin
                            if (rx == CH_ONE || rx == CH_ZERO) begin
                                drive_next     = 4'b0000;
                                tur_ready_next = 1'b1;
                                aim_next       = (rx == CH_ONE);
                            end
                        end
                        CH_T: begin
                            if ((rx == CH_L || rx == CH_R) && tur_ready_reg) begin
                                tur_ready_next = 1'b0;
                                tur_pos_next   = turret_step_pos(tur_pos_reg,
                                    cfg_i.turret_min, cfg_i.turret_max,
                                    cfg_i.turret_step, rx == CH_R);
                                tur_drive_next = tur_pos_next;
                            end
                        end
                        CH_A: begin
                            if (rx >= CH_ZERO && rx <= CH_FIVE) begin
                                speed_next = rx[2:0];
                            end
                        end
                        CH_D: begin
                            if (rx == CH_ONE) begin
                                lights_next = 1'b1;
                            end else if (rx == CH_ZERO) begin
                                lights_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                prev_next = rx;
            end
            OP_FAST: begin
                if (blink_req_reg != 2'b00) begin
                    blink_cnt_next = blink_cnt_reg + 16'd1;
                    if (blink_cnt_next >= cfg_i.blink_half_period) begin
                        blink_cnt_next = 16'd0;
                        // left request wins the lamp toggle
                        lamp_next = lamp_reg ^ (blink_req_reg[1] ? 2'b10 : 2'b01);
                    end
                end else begin
                    lamp_next = 2'b00;
                end
                horn_next = siren_reg && !horn_reg;
            end
            OP_FRAME: begin
                gap_cnt_next = gap_cnt_reg + 8'd1;
                if (gap_cnt_next == cfg_i.turret_gap_ticks) begin
                    tur_ready_next = 1'b1;
                    gap_cnt_next   = 8'd0;
                end
                if (fire_cnt_reg < cfg_i.fire_hold_ticks) begin
                    fire_cnt_next = fire_cnt_reg + 8'd1;
                end else begin
                    fire_drive_next = cfg_i.turret_max;
                end
            end
            default: ;
        endcase

        // speed zero parks the turret
        if (speed_next == 3'd0) begin
            tur_pos_next   = TURRET_PARK;
            tur_drive_next = TURRET_PARK;
        end

        if (done) begin
            priority if (drive_next[3]) begin
                bridge_next = BRIDGE_FWD;
            end else if (drive_next[2]) begin
                bridge_next = BRIDGE_BACK;
            end else if (drive_next[1]) begin
                bridge_next = BRIDGE_LEFT;
            end else if (drive_next[0]) begin
                bridge_next = BRIDGE_RIGHT;
            end else begin
                bridge_next = BRIDGE_STOP;
            end
            // straight motion cancels a finished turn signal, a turn starts it
            if (drive_next[3] || drive_next[2]) begin
                if (blink_mode_next == BLINK_TURN) begin
                    blink_mode_next = BLINK_IDLE;
                    blink_req_next  = 2'b00;
                end
            end else if (drive_next != 4'b0000) begin
                if (blink_mode_next == BLINK_START) begin
                    blink_mode_next = BLINK_TURN;
                end
            end
        end
    end

    always_comb begin
        motor = (speed_next == 3'd0) ? 13'd0 :
                ({3'b000, cfg_i.speed_base} +
                 ({3'b000, cfg_i.speed_slope} * {10'b0, speed_next}));
        m_data_next.bridge_pattern = bridge_next;
        m_data_next.lamp_left      = lamp_next[1];
        m_data_next.lamp_right     = lamp_next[0];
        m_data_next.lights         = lights_next;
        m_data_next.aim_light      = aim_next;
        m_data_next.horn           = horn_next;
        m_data_next.motor_compare  = motor;
        m_data_next.turret_compare = tur_drive_next;
        m_data_next.fire_compare   = fire_drive_next;
        m_data_next.command_done   = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= 8'd0;
            armed_reg      <= 1'b0;
            drive_reg      <= 4'd0;
            bridge_reg     <= BRIDGE_STOP;
            speed_reg      <= RST_SPEED;
            tur_pos_reg    <= RST_TURRET_POS;
            tur_drive_reg  <= TURRET_PARK;
            tur_ready_reg  <= 1'b1;
            gap_cnt_reg    <= 8'd0;
            fire_drive_reg <= RST_FIRE_DRIVE;
            fire_cnt_reg   <= RST_FIRE_COUNT;
            siren_reg      <= 1'b0;
            horn_reg       <= 1'b0;
            blink_req_reg  <= 2'b00;
            blink_mode_reg <= BLINK_IDLE;
            blink_cnt_reg  <= 16'd0;
            lamp_reg       <= 2'b00;
            lights_reg     <= 1'b0;
            aim_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (take_o) begin
                prev_reg       <= prev_next;
                armed_reg      <= armed_next;
                drive_reg      <= drive_next;
                bridge_reg     <= bridge_next;
                speed_reg      <= speed_next;
                tur_pos_reg    <= tur_pos_next;
                tur_drive_reg  <= tur_drive_next;
                tur_ready_reg  <= tur_ready_next;
                gap_cnt_reg    <= gap_cnt_next;
                fire_drive_reg <= fire_drive_next;
                fire_cnt_reg   <= fire_cnt_next;
                siren_reg      <= siren_next;
                horn_reg       <= horn_next;
                blink_req_reg  <= blink_req_next;
                blink_mode_reg <= blink_mode_next;
                blink_cnt_reg  <= blink_cnt_next;
                lamp_reg       <= lamp_next;
                lights_reg     <= lights_next;
                aim_reg        <= aim_next;
            end
            if (take_o) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_o) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== rtl/core/rc_vehicle_command_controller.sv =====
// Vehicle command controller top level. Each input word (a received byte, a fast tick or a
// servo frame tick) yields exactly one result word. The block takes one word per clock and
// keeps that rate as long as results are taken: a word is held in the input register, is
// decoded against the command state, and its result lands in the output register when the
// core takes the word, which it does only while the output register is empty or being read.
// Input and output registers decouple the two sides, so one more word is taken while a
// result waits. Configuration writes are always accepted and apply to every word decoded
// after the write.
module rc_vehicle_command_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rcvc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rcvc_pkg::out_item_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcvc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcvc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcvc_pkg::*;

    cfg_t     cfg;
    logic     take;
    logic     in_valid;
    in_item_t in_item;

    rcvc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    rcvc_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take_i  (take),
        .valid_o (in_valid),
        .item_o  (in_item)
    );

    rcvc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg),
        .in_valid_i (in_valid),
        .item_i     (in_item),
        .take_o     (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/core/rcvc_checker.sv =====
// port-level checks for the vehicle command controller, bound to the top level
module rcvc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rcvc_pkg::out_item_t m_data
);
    import rcvc_pkg::*;

    // words accepted but not yet delivered
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            pending_next = pending_reg + 2'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted word");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two words in flight");

    a_bridge_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.bridge_pattern == BRIDGE_STOP ||
                     m_data.bridge_pattern == BRIDGE_FWD ||
                     m_data.bridge_pattern == BRIDGE_BACK ||
                     m_data.bridge_pattern == BRIDGE_LEFT ||
                     m_data.bridge_pattern == BRIDGE_RIGHT))
        else $error("illegal h-bridge pattern");

endmodule

bind rc_vehicle_command_controller rcvc_checker u_rcvc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
